### hdl/wtsp_pkg.sv
// wtsp_pkg: shared widths, register indexes, stage records and helpers
// for the world-to-screen projection pipeline. No dependencies.
package wtsp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int DIV_W     = WORD_W + FRAC_BITS;
    localparam int COEF_W    = 64;
    localparam int WIN_W     = 16;
    localparam int NUM_COEF  = 6;
    localparam int IDX_W     = 3;
    localparam int PROD_W    = 64;

    // 0.1 in fixed point, rounded down
    localparam logic signed [WORD_W-1:0] THRESH =
        WORD_W'((64'd1 << FRAC_BITS) / 64'd10);

    localparam logic [IDX_W-1:0] REG_X_A = 3'd0;
    localparam logic [IDX_W-1:0] REG_X_B = 3'd1;
    localparam logic [IDX_W-1:0] REG_Y_A = 3'd2;
    localparam logic [IDX_W-1:0] REG_Y_B = 3'd3;
    localparam logic [IDX_W-1:0] REG_W_A = 3'd4;
    localparam logic [IDX_W-1:0] REG_W_B = 3'd5;
    localparam logic [IDX_W-1:0] REG_WIN_W = 3'd6;
    localparam logic [IDX_W-1:0] REG_WIN_H = 3'd7;

    typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_arr_t;

    // one divider step record: num holds the dividend bits not yet used
    // in its top and the quotient bits found so far in its bottom
    typedef struct packed {
        logic              valid;
        logic              vis;
        logic              neg_x;
        logic              neg_y;
        logic [WORD_W-1:0] den;
        logic [DIV_W-1:0]  num_x;
        logic [DIV_W-1:0]  num_y;
        logic [WORD_W-1:0] rem_x;
        logic [WORD_W-1:0] rem_y;
    } div_t;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'($signed({1'b0, {(WORD_W-1){1'b1}}}));
        lo = -hi - PROD_W'(1);
        if (v > hi)
        begin
            return {1'b0, {(WORD_W-1){1'b1}}};
        end
        else if (v < lo)
        begin
            return {1'b1, {(WORD_W-1){1'b0}}};
        end
        return v[WORD_W-1:0];
    endfunction

endpackage

### hdl/wtsp_cfg.sv
// wtsp_cfg: configuration register file (matrix columns, window size).
// Depends on wtsp_pkg.
module wtsp_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [wtsp_pkg::IDX_W-1:0]   cfg_index,
    input  logic [wtsp_pkg::COEF_W-1:0]  cfg_data,
    output wtsp_pkg::coef_arr_t          coef,
    output logic [wtsp_pkg::WIN_W-1:0]   win_w,
    output logic [wtsp_pkg::WIN_W-1:0]   win_h
);

    wtsp_pkg::coef_arr_t             coef_reg;
    logic [wtsp_pkg::WIN_W-1:0]      win_w_reg;
    logic [wtsp_pkg::WIN_W-1:0]      win_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg  <= '0;
            win_w_reg <= 16'd1920;
            win_h_reg <= 16'd1080;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                wtsp_pkg::REG_X_A: coef_reg[0] <= cfg_data;
                wtsp_pkg::REG_X_B: coef_reg[1] <= cfg_data;
                wtsp_pkg::REG_Y_A: coef_reg[2] <= cfg_data;
                wtsp_pkg::REG_Y_B: coef_reg[3] <= cfg_data;
                wtsp_pkg::REG_W_A: coef_reg[4] <= cfg_data;
                wtsp_pkg::REG_W_B: coef_reg[5] <= cfg_data;
                wtsp_pkg::REG_WIN_W: win_w_reg <= cfg_data[wtsp_pkg::WIN_W-1:0];
                wtsp_pkg::REG_WIN_H: win_h_reg <= cfg_data[wtsp_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign coef  = coef_reg;
    assign win_w = win_w_reg;
    assign win_h = win_h_reg;

endmodule

### hdl/wtsp_clip.sv
// wtsp_clip: three-stage front end: products, clip sums with saturation,
// visibility test and divider setup. Depends on wtsp_pkg.
module wtsp_clip (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [wtsp_pkg::WORD_W-1:0]  pos_x,
    input  logic signed [wtsp_pkg::WORD_W-1:0]  pos_y,
    input  logic signed [wtsp_pkg::WORD_W-1:0]  pos_z,
    input  wtsp_pkg::coef_arr_t                 coef,
    output wtsp_pkg::div_t                      div_out
);

    localparam int W = wtsp_pkg::WORD_W;
    localparam int P = wtsp_pkg::PROD_W;
    localparam int F = wtsp_pkg::FRAC_BITS;

    // stage 1: nine products
    logic signed [P-1:0] prod_next [9];
    logic signed [P-1:0] prod_reg  [9];
    logic                v1_reg;
    // stage 2: clip x, y, w
    logic signed [W-1:0] clip_next [3];
    logic signed [W-1:0] clip_reg  [3];
    logic signed [W-1:0] off_reg   [3];
    logic                v2_reg;
    // stage 3
    wtsp_pkg::div_t      div_next;
    wtsp_pkg::div_t      div_reg;

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        logic signed [W-1:0] c_x;
        logic signed [W-1:0] c_y;
        logic signed [W-1:0] c_z;
        logic signed [P-1:0] sum;
        assign c_x = coef[2*r][W-1:0];
        assign c_y = coef[2*r][2*W-1:W];
        assign c_z = coef[2*r+1][W-1:0];
        assign prod_next[3*r]   = pos_x * c_x;
        assign prod_next[3*r+1] = pos_y * c_y;
        assign prod_next[3*r+2] = pos_z * c_z;
        // arithmetic shift right is the floor
        assign sum = (prod_reg[3*r] >>> F) + (prod_reg[3*r+1] >>> F)
                   + (prod_reg[3*r+2] >>> F) + P'(off_reg[r]);
        assign clip_next[r] = wtsp_pkg::sat32(sum);
    end

    logic [W-1:0] mag_x;
    logic [W-1:0] mag_y;

    always_comb
    begin
        mag_x = clip_reg[0][W-1] ? W'(-clip_reg[0]) : W'(clip_reg[0]);
        mag_y = clip_reg[1][W-1] ? W'(-clip_reg[1]) : W'(clip_reg[1]);
        div_next.valid = v2_reg;
        div_next.vis   = (clip_reg[2] >= wtsp_pkg::THRESH);
        div_next.neg_x = clip_reg[0][W-1];
        div_next.neg_y = clip_reg[1][W-1];
        div_next.den   = clip_reg[2];
        div_next.num_x = {mag_x, {F{1'b0}}};
        div_next.num_y = {mag_y, {F{1'b0}}};
        div_next.rem_x = '0;
        div_next.rem_y = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            div_reg <= '0;
        end
        else if (en)
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            div_reg <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            for (int r = 0; r < 3; r++)
            begin
                clip_reg[r] <= clip_next[r];
                off_reg[r]  <= coef[2*r+1][2*W-1:W];
            end
        end
    end

    assign div_out = div_reg;

endmodule

### hdl/wtsp_div_stage.sv
// wtsp_div_stage: one restoring-division step for both lanes, registered.
// Depends on wtsp_pkg.
module wtsp_div_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  wtsp_pkg::div_t d_in,
    output wtsp_pkg::div_t d_out
);

    localparam int W = wtsp_pkg::WORD_W;
    localparam int D = wtsp_pkg::DIV_W;

    wtsp_pkg::div_t d_next;
    wtsp_pkg::div_t d_reg;
    logic [W-1:0]   trial_x;
    logic [W-1:0]   trial_y;
    logic           q_x;
    logic           q_y;

    always_comb
    begin
        // remainder stays below the divisor, so its top bit is free
        trial_x = {d_in.rem_x[W-2:0], d_in.num_x[D-1]};
        trial_y = {d_in.rem_y[W-2:0], d_in.num_y[D-1]};
        q_x     = (trial_x >= d_in.den);
        q_y     = (trial_y >= d_in.den);
        d_next       = d_in;
        d_next.rem_x = q_x ? trial_x - d_in.den : trial_x;
        d_next.rem_y = q_y ? trial_y - d_in.den : trial_y;
        d_next.num_x = {d_in.num_x[D-2:0], q_x};
        d_next.num_y = {d_in.num_y[D-2:0], q_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= '0;
        end
        else if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

### hdl/wtsp_screen.sv
// wtsp_screen: viewport mapping: signed NDC times half window size, offset,
// saturation, output register. Depends on wtsp_pkg.
module wtsp_screen (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  wtsp_pkg::div_t                      d_in,
    input  logic [wtsp_pkg::WIN_W-1:0]          win_w,
    input  logic [wtsp_pkg::WIN_W-1:0]          win_h,
    output logic                                out_valid,
    output logic                                visible,
    output logic signed [wtsp_pkg::WORD_W-1:0]  screen_x,
    output logic signed [wtsp_pkg::WORD_W-1:0]  screen_y
);

    localparam int W  = wtsp_pkg::WORD_W;
    localparam int D  = wtsp_pkg::DIV_W;
    localparam int P  = wtsp_pkg::PROD_W;
    localparam int F  = wtsp_pkg::FRAC_BITS;
    localparam int HW = wtsp_pkg::WIN_W;

    logic signed [D:0]    ndc_x;
    logic signed [D:0]    ndc_y;
    logic signed [HW-1:0] half_w;
    logic signed [HW-1:0] half_h;
    logic signed [P-1:0]  mx_next;
    logic signed [P-1:0]  my_next;
    logic signed [P-1:0]  mx_reg;
    logic signed [P-1:0]  my_reg;
    logic                 mv_reg;
    logic                 mvis_reg;
    logic signed [W-1:0]  sx_next;
    logic signed [W-1:0]  sy_next;
    logic                 ov_reg;
    logic                 vis_reg;
    logic signed [W-1:0]  sx_reg;
    logic signed [W-1:0]  sy_reg;

    assign half_w = $signed({1'b0, win_w[HW-1:1]});
    assign half_h = $signed({1'b0, win_h[HW-1:1]});

    always_comb
    begin
        ndc_x   = d_in.neg_x ? -$signed({1'b0, d_in.num_x}) : $signed({1'b0, d_in.num_x});
        ndc_y   = d_in.neg_y ? -$signed({1'b0, d_in.num_y}) : $signed({1'b0, d_in.num_y});
        mx_next = P'(half_w) * P'(ndc_x);
        my_next = P'(half_h) * P'(ndc_y);
        sx_next = wtsp_pkg::sat32(mx_reg + (P'(half_w) <<< F));
        sy_next = wtsp_pkg::sat32((P'(half_h) <<< F) - my_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            mv_reg <= d_in.valid;
            ov_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg   <= mx_next;
            my_reg   <= my_next;
            mvis_reg <= d_in.vis;
            vis_reg  <= mvis_reg;
            sx_reg   <= mvis_reg ? sx_next : '0;
            sy_reg   <= mvis_reg ? sy_next : '0;
        end
    end

    assign out_valid = ov_reg;
    assign visible   = vis_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;

endmodule

### hdl/world_to_screen_projection.sv
// world_to_screen_projection: top level; config registers, clip front end,
// bit-per-stage divider chain and viewport stage. Depends on wtsp_pkg and all wtsp_* modules.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   in      | request   | in_valid / in_stall   | pos_x, pos_y, pos_z
//   out     | request   | out_valid / out_stall | visible, screen_x, screen_y
//   cfg     | write     | cfg_wr_en             | cfg_index, cfg_data
//
// One request enters per cycle while in_stall is low; requests pass the clip
// front end, the divider chain (one quotient bit per stage) and the viewport stage.
// All stages advance together; in_stall is high only while the output
// register holds a request that is stalled, so nothing is lost or repeated.
// rst_n clears valid bits and loads register reset values.
module world_to_screen_projection (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [wtsp_pkg::WORD_W-1:0]  pos_x,
    input  logic signed [wtsp_pkg::WORD_W-1:0]  pos_y,
    input  logic signed [wtsp_pkg::WORD_W-1:0]  pos_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                visible,
    output logic signed [wtsp_pkg::WORD_W-1:0]  screen_x,
    output logic signed [wtsp_pkg::WORD_W-1:0]  screen_y,
    input  logic                                cfg_wr_en,
    input  logic [wtsp_pkg::IDX_W-1:0]          cfg_index,
    input  logic [wtsp_pkg::COEF_W-1:0]         cfg_data
);

    localparam int D = wtsp_pkg::DIV_W;

    wtsp_pkg::coef_arr_t            coef;
    logic [wtsp_pkg::WIN_W-1:0]     win_w;
    logic [wtsp_pkg::WIN_W-1:0]     win_h;
    logic                           en;
    wtsp_pkg::div_t                 chain [D+1];

    // whole pipe moves unless the result at the output is held back
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    wtsp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef),
        .win_w     (win_w),
        .win_h     (win_h)
    );

    wtsp_clip u_clip (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .coef     (coef),
        .div_out  (chain[0])
    );

    // (clip << FRAC_BITS) / w, magnitudes, one quotient bit per stage
    for (genvar s = 0; s < D; s++)
    begin : g_div
        wtsp_div_stage u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .d_in  (chain[s]),
            .d_out (chain[s+1])
        );
    end

    wtsp_screen u_screen (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .d_in      (chain[D]),
        .win_w     (win_w),
        .win_h     (win_h),
        .out_valid (out_valid),
        .visible   (visible),
        .screen_x  (screen_x),
        .screen_y  (screen_y)
    );

endmodule
